>>> design/byte_stream_tokenizer_unit_defines.svh
// Assertion macros shared by the tokenizer modules.
`ifndef BYTE_STREAM_TOKENIZER_UNIT_DEFINES_SVH
`define BYTE_STREAM_TOKENIZER_UNIT_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define BSTU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define BSTU_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/bst_pkg.sv
package bst_pkg;

  // Run limits and field widths.
  localparam int unsigned MAX_RUN_LENGTH = 63;
  localparam int unsigned PREFIX_BYTES   = 7;
  localparam int unsigned RUN_LEN_W      = 6;
  localparam int unsigned WORD_W         = 8 * PREFIX_BYTES;

  // Depth of the token queue; it must hold at least two tokens.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Token kinds.
  typedef enum logic [1:0] {
    KIND_INT = 2'd0,
    KIND_SEP = 2'd1,
    KIND_KEY = 2'd2,
    KIND_BAD = 2'd3
  } token_kind_t;

  // Separator codes.
  typedef enum logic [1:0] {
    SEP_OPEN  = 2'd0,
    SEP_CLOSE = 2'd1,
    SEP_SEMI  = 2'd2,
    SEP_NONE  = 2'd3
  } sep_code_t;

  // Character codes.
  localparam logic [7:0] CHAR_OPEN  = 8'h28;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;

  // The only keyword, one byte per position.
  localparam logic [7:0] EXIT_WORD [4] = '{8'h65, 8'h78, 8'h69, 8'h74};

  typedef struct packed {
    logic [7:0] in_byte;
    logic       chunk_end;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        token_kind;
    logic [63:0]       number_value;
    logic              number_saturated;
    logic [1:0]        separator_code;
    logic [WORD_W-1:0] word_prefix;
    logic              last_of_item;
  } out_word_t;

  // Tokens produced by one byte, handed to the queue.
  typedef struct packed {
    logic [1:0] count;
    out_word_t  tok0;
    out_word_t  tok1;
  } push_t;

endpackage

>>> design/byte_stream_tokenizer_unit.sv
// Byte stream tokenizer.
// The src channel carries one word per character byte: in_byte and a
// chunk_end flag that closes any open run after that byte. The tok channel
// carries one word per token: integer, separator, keyword exit or invalid
// word, with last_of_item set on the final token a byte causes.
// A byte may cause zero, one or two tokens.
// An accepted byte is held in the input register and leaves it, with its
// tokens written to the output queue, once the queue has room; the first
// token is offered from the queue after that write. Throughput is one
// byte per cycle while each byte yields at most one token and the receiver
// does not stall; for bytes yielding two tokens the drain of the tok side
// sets the rate.
// The input register releases a byte only when the four-entry token queue
// has room for two tokens; when the receiver stalls the queue fills and
// src_ready drops, nothing is lost. Reset clears the open run, the input
// register and the queue; the block takes bytes in the first cycle after.
module byte_stream_tokenizer_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_ready,
  input  bst_pkg::in_word_t  src_word,
  output logic               tok_valid,
  input  logic               tok_ready,
  output bst_pkg::out_word_t tok_word
);
  import bst_pkg::*;

  push_t push;
  logic  space_ok;

  // Tokenizer with its input register.
  bst_core u_core (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_word  (src_word),
    .space_ok  (space_ok),
    .push      (push)
  );

  // Output token queue.
  bst_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space_ok  (space_ok),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_word  (tok_word)
  );

endmodule

>>> design/bst_core.sv
`include "byte_stream_tokenizer_unit_defines.svh"

module bst_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  output logic             src_ready,
  input  bst_pkg::in_word_t src_word,
  input  logic             space_ok,
  output bst_pkg::push_t   push
);
  import bst_pkg::*;

  typedef enum logic [1:0] {
    CLASS_NONE  = 2'd0,
    CLASS_DIGIT = 2'd1,
    CLASS_ALPHA = 2'd2
  } class_t;

  // Input register.
  logic     s1_valid;
  in_word_t s1_word;
  logic     fire;

  // Open run state.
  class_t               run_class, run_class_next;
  logic [RUN_LEN_W-1:0] run_length, run_length_next;
  logic [63:0]          number_accumulator, number_accumulator_next;
  logic                 accumulator_overflow, accumulator_overflow_next;
  logic [WORD_W-1:0]    word_bytes, word_bytes_next;
  logic                 keyword_match, keyword_match_next;

  // Builds the token that closes a run.
  function automatic out_word_t run_token(class_t c, logic [RUN_LEN_W-1:0] len,
                                          logic [63:0] acc, logic ovf,
                                          logic [WORD_W-1:0] word, logic match);
    out_word_t t;
    t = '0;
    if (c == CLASS_DIGIT) begin
      t.token_kind       = KIND_INT;
      t.number_value     = acc;
      t.number_saturated = ovf;
    end else if (match && len == RUN_LEN_W'(4)) begin
      t.token_kind = KIND_KEY;
    end else begin
      t.token_kind  = KIND_BAD;
      t.word_prefix = word;
    end
    return t;
  endfunction

  assign fire      = s1_valid && space_ok;
  assign src_ready = !s1_valid || fire;

  // Per-byte tokenizing: flush of the old run, then the new byte's run or separator.
  always_comb begin
    class_t               cls;
    logic                 flush_old;
    logic                 flush_new;
    logic                 is_sep;
    logic [RUN_LEN_W-1:0] base_len;
    logic [63:0]          base_acc;
    logic                 base_ovf;
    logic [WORD_W-1:0]    base_word;
    logic                 base_match;
    logic [67:0]          sum;
    logic [7:0]           b;
    out_word_t            t_old;
    out_word_t            t_second;
    out_word_t            t_sep;

    b = s1_word.in_byte;
    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
      cls = CLASS_DIGIT;
    end else if ((b >= CHAR_LO_A && b <= CHAR_LO_Z) || (b >= CHAR_UP_A && b <= CHAR_UP_Z)) begin
      cls = CLASS_ALPHA;
    end else begin
      cls = CLASS_NONE;
    end

    flush_old = (run_class != CLASS_NONE) && (run_class != cls);
    t_old = run_token(run_class, run_length, number_accumulator, accumulator_overflow,
                      word_bytes, keyword_match);

    // Run state as seen by the new byte.
    base_len   = flush_old ? '0 : run_length;
    base_acc   = flush_old ? '0 : number_accumulator;
    base_ovf   = flush_old ? 1'b0 : accumulator_overflow;
    base_word  = flush_old ? '0 : word_bytes;
    base_match = flush_old ? 1'b1 : keyword_match;

    // Decimal step: acc * 10 + digit, saturating past 64 bits.
    sum = {1'b0, base_acc, 3'b000} + {3'b000, base_acc, 1'b0}
        + {64'd0, 4'(b - CHAR_ZERO)};

    run_class_next            = run_class;
    run_length_next           = base_len + RUN_LEN_W'(1);
    number_accumulator_next   = base_acc;
    accumulator_overflow_next = base_ovf;
    word_bytes_next           = base_word;
    keyword_match_next        = base_match;

    if (cls == CLASS_DIGIT) begin
      accumulator_overflow_next = base_ovf || (sum[67:64] != 4'd0);
      number_accumulator_next   = accumulator_overflow_next ? '1 : sum[63:0];
    end else begin
      for (int i = 0; i < PREFIX_BYTES; i++) begin
        if (base_len == RUN_LEN_W'(i)) begin
          word_bytes_next[8*i +: 8] = b;
        end
      end
      if (base_len >= RUN_LEN_W'(4) || EXIT_WORD[base_len[1:0]] != b) begin
        keyword_match_next = 1'b0;
      end
    end

    flush_new = (cls != CLASS_NONE)
             && (run_length_next >= RUN_LEN_W'(MAX_RUN_LENGTH) || s1_word.chunk_end);

    // Separator token.
    t_sep = '0;
    t_sep.token_kind = KIND_SEP;
    is_sep = 1'b1;
    case (b)
      CHAR_OPEN:  t_sep.separator_code = SEP_OPEN;
      CHAR_CLOSE: t_sep.separator_code = SEP_CLOSE;
      CHAR_SEMI:  t_sep.separator_code = SEP_SEMI;
      default:    is_sep = 1'b0;
    endcase
    if (cls == CLASS_NONE) begin
      t_second = t_sep;
    end else begin
      t_second = run_token(cls, run_length_next, number_accumulator_next,
                           accumulator_overflow_next, word_bytes_next, keyword_match_next);
    end

    // Next run state.
    if (cls == CLASS_NONE || flush_new) begin
      run_class_next            = CLASS_NONE;
      run_length_next           = '0;
      number_accumulator_next   = '0;
      accumulator_overflow_next = 1'b0;
      word_bytes_next           = '0;
      keyword_match_next        = 1'b1;
    end else begin
      run_class_next = cls;
    end

    // Pack the tokens, the last one flagged.
    push = '0;
    t_old.last_of_item    = 1'b0;
    t_second.last_of_item = 1'b1;
    if (fire) begin
      if (flush_old && (flush_new || is_sep)) begin
        push.count = 2'd2;
        push.tok0  = t_old;
        push.tok1  = t_second;
      end else if (flush_old) begin
        push.count = 2'd1;
        push.tok0  = t_old;
        push.tok0.last_of_item = 1'b1;
      end else if (flush_new || (cls == CLASS_NONE && is_sep)) begin
        push.count = 2'd1;
        push.tok0  = t_second;
      end
    end
  end

  // Input register and run state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid             <= 1'b0;
      run_class            <= CLASS_NONE;
      run_length           <= '0;
      number_accumulator   <= '0;
      accumulator_overflow <= 1'b0;
      word_bytes           <= '0;
      keyword_match        <= 1'b1;
    end else begin
      if (src_ready) begin
        s1_valid <= src_valid;
        s1_word  <= src_word;
      end
      if (fire) begin
        run_class            <= run_class_next;
        run_length           <= run_length_next;
        number_accumulator   <= number_accumulator_next;
        accumulator_overflow <= accumulator_overflow_next;
        word_bytes           <= word_bytes_next;
        keyword_match        <= keyword_match_next;
      end
    end
  end

  `BSTU_ASSERT(a_len_matches_class, (run_class == CLASS_NONE) == (run_length == '0), "run length and class disagree")
  `BSTU_ASSERT(a_chunk_end_flushes, (fire && s1_word.chunk_end) |=> (run_class == CLASS_NONE), "run open after chunk end")
  `BSTU_ASSERT(a_pair_last_flag, (push.count == 2'd2) |-> (!push.tok0.last_of_item && push.tok1.last_of_item), "bad last flag")
  `BSTU_ASSERT(a_push_needs_word, (push.count != 2'd0) |-> fire, "token without a byte")

endmodule

>>> design/bst_out_fifo.sv
`include "byte_stream_tokenizer_unit_defines.svh"

module bst_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  bst_pkg::push_t     push,
  output logic               space_ok,
  output logic               tok_valid,
  input  logic               tok_ready,
  output bst_pkg::out_word_t tok_word
);
  import bst_pkg::*;

  out_word_t             mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  pop;

  assign tok_valid = (count != '0);
  assign tok_word  = mem[rd_ptr];
  assign pop       = tok_valid && tok_ready;
  // Room for a full pair of tokens.
  assign space_ok  = (count <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  // Token storage.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.tok0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + FIFO_PTR_W'(1)] <= push.tok1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      count <= count + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end
  end

  `BSTU_ASSERT(a_count_bound, count <= FIFO_CNT_W'(FIFO_DEPTH), "token queue overfilled")
  `BSTU_ASSERT(a_push_fits, (push.count != 2'd0) |-> space_ok, "push without room")
  `BSTU_ASSERT_ALWAYS(a_reset_empties, rst |=> (count == '0), "token queue not empty after reset")

endmodule
